[rtl/page_frame_refcount_allocator_macros.svh]
// Assertion macros shared by the page frame allocator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_REFCOUNT_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PFRA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PFRA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pfra_pkg.sv]
// Shared types and constants for the page frame allocator.
// No dependencies.
package pfra_pkg;
    localparam int NumFrames = 4096;
    localparam int IdxW      = 12;
    localparam int CntW      = 13;
    localparam int RefW      = 16;
    localparam int OwnW      = 16;
    localparam logic [RefW-1:0] RefTop = {RefW{1'b1}};

    typedef enum logic [2:0] {
        CMD_ALLOC_RUN = 3'd0, CMD_ALLOC_USER = 3'd1, CMD_RETAIN = 3'd2,
        CMD_RELEASE = 3'd3, CMD_RESERVE = 3'd4, CMD_SET_OWNER = 3'd5,
        CMD_RECLAIM = 3'd6, CMD_QUERY = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOFREE = 2'd1, ST_INVALID = 2'd2, ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_FRAMES = 2'd0, CFG_ZERO_EN = 2'd1, CFG_ZERO_IDX = 2'd2
    } cfg_idx_t;
endpackage

[rtl/page_frame_refcount_allocator.sv]
// Page frame allocator with per-frame reference count and owner tables.
// Depends on pfra_pkg and page_frame_refcount_allocator_macros.svh.
//
// One command item is handled at a time; s_axis_tready is low while it runs.
// Both tables are single-port memories and one scanner walks them one entry
// at a time (read, then decide and write), so allocation, reclaim, reserve
// and set owner step through frames this way. A first-fit search visits every
// managed frame at most once over both passes and then fills the run one
// frame per cycle. Retain, release and query read and update a single entry.
// After reset a clearing pass zeroes both tables before the first item is
// taken.
`include "page_frame_refcount_allocator_macros.svh"

module page_frame_refcount_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], frame_index[14:3], run_length[27:15], owner_id[43:28]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], result_index[13:2], ref_count[29:14]
    output logic [31:0] m_axis_tdata
);
    localparam int IW = pfra_pkg::IdxW;
    localparam int CW = pfra_pkg::CntW;
    localparam int RW = pfra_pkg::RefW;
    localparam int OW = pfra_pkg::OwnW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_RD, S_EVAL, S_WR_RUN, S_DONE
    } state_t;

    // Phases of a scan.
    typedef enum logic [3:0] {
        P_RUN, P_USER, P_SINGLE, P_RES_CHK, P_RES_WR, P_OWN, P_RECLAIM, P_FILL
    } phase_t;

    logic [RW-1:0] refs_mem [pfra_pkg::NumFrames];
    logic [OW-1:0] own_mem  [pfra_pkg::NumFrames];

    state_t state_reg;
    phase_t phase_reg;
    logic [CW-1:0] frames_reg;
    logic          zen_reg;
    logic [IW-1:0] zidx_reg;
    logic [IW-1:0] low_hint_reg;
    logic [CW-1:0] top_hint_reg;
    pfra_pkg::cmd_t cmd_reg;
    logic [IW-1:0] fidx_reg;
    logic [CW-1:0] len_reg;
    logic [OW-1:0] owner_reg;
    logic [CW-1:0] ptr_reg;     // current entry
    logic [CW-1:0] lim_reg;     // end of pass
    logic [CW-1:0] run_reg;
    logic          pass_reg;
    logic [RW-1:0] rref_reg;
    logic [OW-1:0] rown_reg;
    logic [1:0]    st_reg;
    logic [IW-1:0] res_reg;
    logic [RW-1:0] cnt_reg;
    logic          ovalid_reg;

    logic [CW-1:0] managed;
    logic          mem_we;
    logic [IW-1:0] mem_addr;
    logic [RW-1:0] ref_wd;
    logic [OW-1:0] own_wd;
    logic          own_we;
    logic [CW-1:0] top_below;

    assign managed = (frames_reg > CW'(pfra_pkg::NumFrames)) ?
                     CW'(pfra_pkg::NumFrames) : frames_reg;
    assign top_below = top_hint_reg - CW'(1);
    // The user scan reads the frame just below the hint while it steps down.
    assign mem_addr = (state_reg == S_RD && phase_reg == P_USER) ?
                      top_below[IW-1:0] : ptr_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            refs_mem[mem_addr] <= ref_wd;
        end
        if (own_we) begin
            own_mem[mem_addr] <= own_wd;
        end
        rref_reg <= refs_mem[mem_addr];
        rown_reg <= own_mem[mem_addr];
    end

    // Release of the frame just read, shared by release and reclaim.
    logic zero_hit, rel_ok, ret_ok;
    logic [RW-1:0] rel_val;
    assign zero_hit = zen_reg && (ptr_reg[IW-1:0] == zidx_reg);
    assign rel_ok   = (ptr_reg < managed) && (rref_reg != '0) &&
                      (rref_reg != pfra_pkg::RefTop);
    assign ret_ok   = (ptr_reg < managed) && (rref_reg != '0) &&
                      (rref_reg < pfra_pkg::RefTop - RW'(1));
    assign rel_val  = rref_reg - RW'(1);

    always_comb begin
        mem_we = 1'b0;
        own_we = 1'b0;
        ref_wd = '0;
        own_wd = '0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
                own_we = 1'b1;
            end
            S_EVAL: begin
                unique case (phase_reg)
                    P_USER: begin
                        if (rref_reg == '0) begin
                            mem_we = 1'b1; own_we = 1'b1; ref_wd = RW'(1);
                        end
                    end
                    P_SINGLE: begin
                        if (cmd_reg == pfra_pkg::CMD_RETAIN) begin
                            if (!zero_hit && ret_ok) begin
                                mem_we = 1'b1; own_we = 1'b1;
                                ref_wd = rref_reg + RW'(1);
                            end
                        end else if (cmd_reg == pfra_pkg::CMD_RELEASE) begin
                            if (!zero_hit && rel_ok) begin
                                mem_we = 1'b1; ref_wd = rel_val;
                                own_we = (rel_val == '0);
                            end
                        end
                    end
                    P_RECLAIM: begin
                        if (rown_reg == owner_reg && !zero_hit && rel_ok) begin
                            mem_we = 1'b1; ref_wd = rel_val;
                            own_we = (rel_val == '0);
                        end
                    end
                    P_OWN: begin
                        if (rref_reg == RW'(1)) begin
                            own_we = 1'b1; own_wd = owner_reg;
                        end
                    end
                    default: ;
                endcase
            end
            S_WR_RUN: begin
                unique case (phase_reg)
                    P_RES_WR: begin
                        mem_we = 1'b1; ref_wd = pfra_pkg::RefTop;
                    end
                    P_FILL: begin
                        mem_we = 1'b1; own_we = 1'b1; ref_wd = RW'(1);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    logic [CW-1:0] first_c;
    logic [CW:0]   end_c;
    assign first_c = ptr_reg + CW'(1) - len_reg;
    assign end_c   = {1'b0, fidx_reg} + {1'b0, len_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            phase_reg    <= P_RUN;
            ptr_reg      <= '0;
            frames_reg   <= CW'(pfra_pkg::NumFrames);
            zen_reg      <= 1'b0;
            zidx_reg     <= '0;
            low_hint_reg <= '0;
            top_hint_reg <= CW'(pfra_pkg::NumFrames);
            ovalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    pfra_pkg::CFG_FRAMES:   frames_reg <= cfg_data;
                    pfra_pkg::CFG_ZERO_EN:  zen_reg <= cfg_data[0];
                    pfra_pkg::CFG_ZERO_IDX: zidx_reg <= cfg_data[IW-1:0];
                    default: ;
                endcase
            end
            if (ovalid_reg && m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    ptr_reg <= ptr_reg + CW'(1);
                    if (ptr_reg == CW'(pfra_pkg::NumFrames - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid && !ovalid_reg) begin
                        cmd_reg   <= pfra_pkg::cmd_t'(s_axis_tdata[2:0]);
                        fidx_reg  <= s_axis_tdata[14:3];
                        len_reg   <= s_axis_tdata[27:15];
                        owner_reg <= s_axis_tdata[43:28];
                        st_reg    <= pfra_pkg::ST_OK;
                        res_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    run_reg  <= '0;
                    pass_reg <= 1'b0;
                    unique case (cmd_reg)
                        pfra_pkg::CMD_ALLOC_RUN: begin
                            phase_reg <= P_RUN;
                            if (len_reg == '0) begin
                                st_reg <= pfra_pkg::ST_RANGE;
                                state_reg <= S_DONE;
                            end else begin
                                ptr_reg  <= {1'b0, low_hint_reg};
                                lim_reg  <= managed;
                                state_reg <= S_RD;
                                if ({1'b0, low_hint_reg} >= managed) begin
                                    pass_reg <= 1'b1;
                                    ptr_reg  <= '0;
                                end
                            end
                        end
                        pfra_pkg::CMD_ALLOC_USER: begin
                            phase_reg <= P_USER;
                            if (top_hint_reg > managed) begin
                                top_hint_reg <= managed;
                            end
                            state_reg <= S_RD;
                        end
                        pfra_pkg::CMD_RETAIN, pfra_pkg::CMD_RELEASE: begin
                            phase_reg <= P_SINGLE;
                            ptr_reg   <= {1'b0, fidx_reg};
                            state_reg <= S_RD;
                        end
                        pfra_pkg::CMD_RESERVE: begin
                            phase_reg <= P_RES_CHK;
                            ptr_reg   <= {1'b0, fidx_reg};
                            if (len_reg == '0 || end_c > {1'b0, managed}) begin
                                st_reg <= pfra_pkg::ST_RANGE;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end
                        pfra_pkg::CMD_SET_OWNER: begin
                            phase_reg <= P_OWN;
                            ptr_reg   <= {1'b0, fidx_reg};
                            if (len_reg == '0) begin
                                state_reg <= S_DONE;
                            end else if (end_c > {1'b0, managed}) begin
                                st_reg <= pfra_pkg::ST_RANGE;
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end
                        pfra_pkg::CMD_RECLAIM: begin
                            phase_reg <= P_RECLAIM;
                            ptr_reg   <= '0;
                            state_reg <= (owner_reg == '0 || managed == '0) ?
                                         S_DONE : S_RD;
                        end
                        pfra_pkg::CMD_QUERY: begin
                            phase_reg <= P_SINGLE;
                            ptr_reg   <= {1'b0, fidx_reg};
                            state_reg <= S_RD;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_RD: begin
                    // The user scan reads below the hint; an exhausted scan ends here.
                    if (phase_reg == P_USER) begin
                        if (top_hint_reg == '0) begin
                            st_reg <= pfra_pkg::ST_NOFREE;
                            state_reg <= S_DONE;
                        end else begin
                            ptr_reg <= top_below;
                            top_hint_reg <= top_below;
                            state_reg <= S_EVAL;
                        end
                    end else if (phase_reg == P_RUN && ptr_reg >= lim_reg) begin
                        if (!pass_reg) begin
                            pass_reg <= 1'b1;
                            run_reg  <= '0;
                            ptr_reg  <= '0;
                            lim_reg  <= {1'b0, low_hint_reg};
                        end else begin
                            st_reg <= pfra_pkg::ST_NOFREE;
                            state_reg <= S_DONE;
                        end
                    end else begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    state_reg <= S_RD;
                    unique case (phase_reg)
                        P_RUN: begin
                            if (rref_reg != '0) begin
                                run_reg <= '0;
                                ptr_reg <= ptr_reg + CW'(1);
                            end else if (run_reg + CW'(1) == len_reg) begin
                                res_reg <= first_c[IW-1:0];
                                low_hint_reg <= (ptr_reg + CW'(1) < managed) ?
                                    ptr_reg[IW-1:0] + IW'(1) : '0;
                                lim_reg <= ptr_reg + CW'(1);
                                ptr_reg <= first_c;
                                phase_reg <= P_FILL;
                                state_reg <= S_WR_RUN;
                            end else begin
                                run_reg <= run_reg + CW'(1);
                                ptr_reg <= ptr_reg + CW'(1);
                            end
                        end
                        P_USER: begin
                            if (rref_reg == '0) begin
                                res_reg <= ptr_reg[IW-1:0];
                                state_reg <= S_DONE;
                            end
                        end
                        P_SINGLE: begin
                            state_reg <= S_DONE;
                            if (cmd_reg == pfra_pkg::CMD_QUERY) begin
                                cnt_reg <= (ptr_reg < managed) ? rref_reg : '0;
                            end else if (zero_hit) begin
                                st_reg <= pfra_pkg::ST_OK;
                            end else if (cmd_reg == pfra_pkg::CMD_RETAIN) begin
                                if (!ret_ok) st_reg <= pfra_pkg::ST_INVALID;
                            end else if (!rel_ok) begin
                                st_reg <= pfra_pkg::ST_INVALID;
                            end else if (rel_val == '0) begin
                                if (ptr_reg[IW-1:0] < low_hint_reg) begin
                                    low_hint_reg <= ptr_reg[IW-1:0];
                                end
                                if (ptr_reg >= top_hint_reg) begin
                                    top_hint_reg <= ptr_reg + CW'(1);
                                end
                            end
                        end
                        P_RECLAIM: begin
                            if (rown_reg == owner_reg && !zero_hit && rel_ok &&
                                rel_val == '0) begin
                                if (ptr_reg[IW-1:0] < low_hint_reg) begin
                                    low_hint_reg <= ptr_reg[IW-1:0];
                                end
                                if (ptr_reg >= top_hint_reg) begin
                                    top_hint_reg <= ptr_reg + CW'(1);
                                end
                            end
                            ptr_reg <= ptr_reg + CW'(1);
                            if (ptr_reg + CW'(1) >= managed) state_reg <= S_DONE;
                        end
                        P_RES_CHK: begin
                            if (rref_reg != pfra_pkg::RefTop && rref_reg != '0) begin
                                st_reg <= pfra_pkg::ST_RANGE;
                                state_reg <= S_DONE;
                            end else if (ptr_reg + CW'(1) == end_c[CW-1:0]) begin
                                ptr_reg <= {1'b0, fidx_reg};
                                phase_reg <= P_RES_WR;
                                state_reg <= S_WR_RUN;
                            end else begin
                                ptr_reg <= ptr_reg + CW'(1);
                            end
                        end
                        P_OWN: begin
                            ptr_reg <= ptr_reg + CW'(1);
                            if (ptr_reg + CW'(1) == end_c[CW-1:0]) state_reg <= S_DONE;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_WR_RUN: begin
                    ptr_reg <= ptr_reg + CW'(1);
                    if (phase_reg == P_FILL) begin
                        if (ptr_reg + CW'(1) == lim_reg) state_reg <= S_DONE;
                    end else if (ptr_reg + CW'(1) == end_c[CW-1:0]) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {2'b00, cnt_reg, res_reg, st_reg};

    `PFRA_ASSERT_IMP(a_no_accept_busy, aclk, aresetn,
        state_reg != S_IDLE, !s_axis_tready, "input taken while busy")
    `PFRA_ASSERT_NEXT(a_done_valid, aclk, aresetn,
        state_reg == S_DONE, m_axis_tvalid, "result not presented")
    `PFRA_ASSERT_IMP(a_top_hint, aclk, aresetn,
        1'b1, top_hint_reg <= CW'(pfra_pkg::NumFrames), "user hint out of range")
endmodule
